### hw/rtl/rotation_matrix_to_quaternion_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotation matrix to quaternion checker.
// Each macro expands to one labeled concurrent assertion on the rising clock.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// Assertion that is ignored while reset is high.
`define RMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked during reset.
`define RMQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and branch codes of the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  // Branch code reported with every result.
  typedef logic [1:0] branch_t;

  localparam branch_t BR_TRACE = 2'd0;  // Positive trace.
  localparam branch_t BR_X     = 2'd1;  // Largest diagonal on x.
  localparam branch_t BR_Y     = 2'd2;  // Largest diagonal on y.
  localparam branch_t BR_Z     = 2'd3;  // Largest diagonal on z.

endpackage

`default_nettype wire

### hw/rtl/rmq_if.sv
// ----------------------------------------------------------------------------
// rmq_mat_if / rmq_quat_if
// Valid/ready channels for the matrix beat and the quaternion beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmq_mat_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] m_r0c0;
  logic signed [W-1:0] m_r0c1;
  logic signed [W-1:0] m_r0c2;
  logic signed [W-1:0] m_r1c0;
  logic signed [W-1:0] m_r1c1;
  logic signed [W-1:0] m_r1c2;
  logic signed [W-1:0] m_r2c0;
  logic signed [W-1:0] m_r2c1;
  logic signed [W-1:0] m_r2c2;

  modport source (
    output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2,
    input  ready
  );
  modport sink (
    input  valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2,
    output ready
  );
endinterface

interface rmq_quat_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] quat_x;
  logic signed [W-1:0] quat_y;
  logic signed [W-1:0] quat_z;
  logic signed [W-1:0] quat_w;
  rmq_pkg::branch_t    branch_taken;

  modport source (
    output valid, quat_x, quat_y, quat_z, quat_w, branch_taken,
    input  ready
  );
  modport sink (
    input  valid, quat_x, quat_y, quat_z, quat_w, branch_taken,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one root bit per register stage, with a
// sideband word that travels alongside the radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt #(
  parameter int RAD_BITS  = 33,
  parameter int SIDE_BITS = 53
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          en,
  input  wire                          in_valid,
  input  wire  [RAD_BITS-1:0]          rad,
  input  wire  [SIDE_BITS-1:0]         side,
  output logic                         out_valid,
  output logic [(RAD_BITS+1)/2-1:0]    root,
  output logic [SIDE_BITS-1:0]         side_out
);

  localparam int NI  = (RAD_BITS + 1) / 2;
  localparam int RWE = 2 * NI;
  localparam int RMW = NI + 2;

  // Stage registers, entry n holds the state after step n.
  logic                 vld   [NI];
  logic [RWE-1:0]       rr    [NI];
  logic [RMW-1:0]       rm    [NI];
  logic [NI-1:0]        rt    [NI];
  logic [SIDE_BITS-1:0] sd    [NI];

  // Inputs of each step.
  logic                 c_vld [NI];
  logic [RWE-1:0]       c_rr  [NI];
  logic [RMW-1:0]       c_rm  [NI];
  logic [NI-1:0]        c_rt  [NI];
  logic [SIDE_BITS-1:0] c_sd  [NI];

  // Step results.
  logic [RMW+1:0]       cat   [NI];
  logic [RMW+1:0]       trial [NI];
  logic [RMW-1:0]       rm_nx [NI];
  logic [NI-1:0]        rt_nx [NI];

  // Each step brings down one radicand bit pair and decides one root bit.
  always_comb begin
    for (int n = 0; n < NI; n++) begin
      if (n == 0) begin
        c_vld[n] = in_valid;
        c_rr[n]  = {{(RWE-RAD_BITS){1'b0}}, rad};
        c_rm[n]  = '0;
        c_rt[n]  = '0;
        c_sd[n]  = side;
      end else begin
        c_vld[n] = vld[n-1];
        c_rr[n]  = rr[n-1];
        c_rm[n]  = rm[n-1];
        c_rt[n]  = rt[n-1];
        c_sd[n]  = sd[n-1];
      end
      cat[n]   = {c_rm[n], c_rr[n][RWE-1 -: 2]};
      trial[n] = {2'b00, c_rt[n], 2'b01};
      if (cat[n] >= trial[n]) begin
        rm_nx[n] = RMW'(cat[n] - trial[n]);
        rt_nx[n] = {c_rt[n][NI-2:0], 1'b1};
      end else begin
        rm_nx[n] = cat[n][RMW-1:0];
        rt_nx[n] = {c_rt[n][NI-2:0], 1'b0};
      end
    end
  end

  // Valid bits, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NI; n++) vld[n] <= 1'b0;
    end else if (en) begin
      for (int n = 0; n < NI; n++) vld[n] <= c_vld[n];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < NI; n++) begin
        rr[n] <= c_rr[n] << 2;
        rm[n] <= rm_nx[n];
        rt[n] <= rt_nx[n];
        sd[n] <= c_sd[n];
      end
    end
  end

  assign out_valid = vld[NI-1];
  assign root      = rt[NI-1];
  assign side_out  = sd[NI-1];

endmodule

`default_nettype wire

### hw/rtl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a fixed-point 3x3 rotation matrix to a quaternion.
// ----------------------------------------------------------------------------
// The block takes one matrix beat per cycle while the output is not stalled
// and returns one quaternion beat per matrix, in order. The stages are, in order:
// a setup stage, one square root stage per root bit (there are NI =
// (max(WORD_BITS, FRAC_BITS) + 3 + FRAC_BITS + 1) / 2 root bits), a divisor
// setup stage, one restoring division stage per quotient bit (three lanes in
// parallel), and the output register.
// The whole pipeline advances when the output register is empty or taken, so
// a stall at the output holds every stage in place.
`default_nettype none

module rotation_matrix_to_quaternion #(
  parameter int WORD_BITS = 16,
  parameter int FRAC_BITS = 14
) (
  input  wire          clk,
  input  wire          rst,
  rmq_mat_if.sink      mat,
  rmq_quat_if.source   quat
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int AW  = ((W > F) ? W : F) + 3;
  localparam int RB  = AW + F;
  localparam int NI  = (RB + 1) / 2;
  localparam int DW  = W + 1;
  localparam int NW  = W + F + 2;
  localparam int QB  = W;
  localparam int DSW = NI + 1 + QB;
  localparam int CW  = ((NW > DSW) ? NW : DSW) + 1;
  localparam int SB  = 3 * DW + 2;

  localparam logic signed [AW:0] ONE  = (AW+1)'(1) << F;
  localparam logic [W-1:0]       SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]       SMIN = {1'b1, {(W-1){1'b0}}};

  logic en;

  // Sign-extended elements.
  logic signed [AW:0] e00, e11, e22;
  logic signed [DW-1:0] d01, d02, d10, d12, d20, d21;
  logic signed [AW:0] tr, rad_s;
  rmq_pkg::branch_t br_c;
  logic signed [DW-1:0] ta_c, tb_c, tc_c;

  // Setup stage registers.
  logic                 p_vld;
  logic [AW-1:0]        p_rad;
  logic [DW-1:0]        p_a, p_b, p_c;
  rmq_pkg::branch_t     p_br;

  // Square root outputs.
  logic                 sq_vld;
  logic [NI-1:0]        sq_root;
  logic [SB-1:0]        sq_side;

  // Divisor setup stage.
  logic                 v_vld;
  logic [CW-1:0]        v_r    [3];
  logic                 v_neg  [3];
  logic                 v_ovf  [3];
  logic [CW-1:0]        v_d;
  logic [W-1:0]         v_h;
  logic                 v_zero;
  rmq_pkg::branch_t     v_br;

  logic signed [DW-1:0] s_t    [3];
  logic [DW-1:0]        s_mag  [3];
  logic [CW-1:0]        s_num  [3];
  logic [CW-1:0]        s_d;
  logic [NI:0]          s_h;

  // Division stage registers and step inputs.
  logic                 dv_vld  [QB];
  logic [CW-1:0]        dv_r    [QB][3];
  logic [QB-1:0]        dv_q    [QB][3];
  logic                 dv_neg  [QB][3];
  logic                 dv_ovf  [QB][3];
  logic [CW-1:0]        dv_d    [QB];
  logic [W-1:0]         dv_h    [QB];
  logic                 dv_zero [QB];
  rmq_pkg::branch_t     dv_br   [QB];

  logic                 c_vld  [QB];
  logic [CW-1:0]        c_r    [QB][3];
  logic [QB-1:0]        c_q    [QB][3];
  logic                 c_neg  [QB][3];
  logic                 c_ovf  [QB][3];
  logic [CW-1:0]        c_d    [QB];
  logic [W-1:0]         c_h    [QB];
  logic                 c_zero [QB];
  rmq_pkg::branch_t     c_br   [QB];
  logic [CW-1:0]        c_sub  [QB];
  logic [CW-1:0]        r_nx   [QB][3];
  logic [QB-1:0]        q_nx   [QB][3];

  // Final lane values.
  logic [W-1:0]         f_t    [3];
  logic [W-1:0]         f_x, f_y, f_z, f_w;

  // Output register.
  logic                 o_vld;
  logic [W-1:0]         o_x, o_y, o_z, o_w;
  rmq_pkg::branch_t     o_br;

  // The pipeline moves whenever the output register can take a beat.
  assign en        = !o_vld || quat.ready;
  assign mat.ready = en;

  // Trace, pivot axis, radicand and the three sum or difference terms.
  always_comb begin
    e00 = (AW+1)'(mat.m_r0c0);
    e11 = (AW+1)'(mat.m_r1c1);
    e22 = (AW+1)'(mat.m_r2c2);
    d01 = DW'(mat.m_r0c1);
    d02 = DW'(mat.m_r0c2);
    d10 = DW'(mat.m_r1c0);
    d12 = DW'(mat.m_r1c2);
    d20 = DW'(mat.m_r2c0);
    d21 = DW'(mat.m_r2c1);
    tr  = e00 + e11 + e22;
    if (tr > 0) begin
      br_c  = rmq_pkg::BR_TRACE;
      rad_s = tr + ONE;
      ta_c  = d12 - d21;
      tb_c  = d20 - d02;
      tc_c  = d01 - d10;
    end else if (e22 > ((e11 > e00) ? e11 : e00)) begin
      br_c  = rmq_pkg::BR_Z;
      rad_s = e22 - (e00 + e11) + ONE;
      ta_c  = d20 + d02;
      tb_c  = d21 + d12;
      tc_c  = d01 - d10;
    end else if (e11 > e00) begin
      br_c  = rmq_pkg::BR_Y;
      rad_s = e11 - (e22 + e00) + ONE;
      ta_c  = d12 + d21;
      tb_c  = d10 + d01;
      tc_c  = d20 - d02;
    end else begin
      br_c  = rmq_pkg::BR_X;
      rad_s = e00 - (e11 + e22) + ONE;
      ta_c  = d01 + d10;
      tb_c  = d02 + d20;
      tc_c  = d12 - d21;
    end
    if (rad_s < 0) begin
      rad_s = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= mat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_rad <= rad_s[AW-1:0];
      p_a   <= ta_c;
      p_b   <= tb_c;
      p_c   <= tc_c;
      p_br  <= br_c;
    end
  end

  // Root of the radicand scaled by 2^FRAC_BITS.
  rmq_sqrt #(
    .RAD_BITS  (RB),
    .SIDE_BITS (SB)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_vld),
    .rad       ({p_rad, {F{1'b0}}}),
    .side      ({p_br, p_a, p_b, p_c}),
    .out_valid (sq_vld),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  // Dividends, divisor 2s, overflow checks and the half root.
  always_comb begin
    s_t[0] = sq_side[3*DW-1 -: DW];
    s_t[1] = sq_side[2*DW-1 -: DW];
    s_t[2] = sq_side[DW-1 -: DW];
    s_d    = CW'({sq_root, 1'b0});
    for (int l = 0; l < 3; l++) begin
      s_mag[l] = s_t[l][DW-1] ? DW'(-s_t[l]) : DW'(s_t[l]);
      s_num[l] = (CW'(s_mag[l]) << F) + CW'(sq_root);
    end
    s_h = ({1'b0, sq_root} + (NI+1)'(1)) >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_vld <= 1'b0;
    end else if (en) begin
      v_vld <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        v_r[l]   <= s_num[l];
        v_neg[l] <= s_t[l][DW-1];
        v_ovf[l] <= s_num[l] >= (s_d << QB);
      end
      v_d    <= s_d;
      v_h    <= (CW'(s_h) > CW'(SMAX)) ? SMAX : W'(s_h);
      v_zero <= (sq_root == '0);
      v_br   <= sq_side[SB-1 -: 2];
    end
  end

  // Restoring division, one quotient bit per stage for each of three lanes.
  always_comb begin
    for (int k = 0; k < QB; k++) begin
      if (k == 0) begin
        c_vld[k]  = v_vld;
        c_d[k]    = v_d;
        c_h[k]    = v_h;
        c_zero[k] = v_zero;
        c_br[k]   = v_br;
        for (int l = 0; l < 3; l++) begin
          c_r[k][l]   = v_r[l];
          c_q[k][l]   = '0;
          c_neg[k][l] = v_neg[l];
          c_ovf[k][l] = v_ovf[l];
        end
      end else begin
        c_vld[k]  = dv_vld[k-1];
        c_d[k]    = dv_d[k-1];
        c_h[k]    = dv_h[k-1];
        c_zero[k] = dv_zero[k-1];
        c_br[k]   = dv_br[k-1];
        for (int l = 0; l < 3; l++) begin
          c_r[k][l]   = dv_r[k-1][l];
          c_q[k][l]   = dv_q[k-1][l];
          c_neg[k][l] = dv_neg[k-1][l];
          c_ovf[k][l] = dv_ovf[k-1][l];
        end
      end
      c_sub[k] = c_d[k] << (QB - 1 - k);
      for (int l = 0; l < 3; l++) begin
        q_nx[k][l] = c_q[k][l];
        if (c_r[k][l] >= c_sub[k]) begin
          r_nx[k][l] = c_r[k][l] - c_sub[k];
          q_nx[k][l][QB-1-k] = 1'b1;
        end else begin
          r_nx[k][l] = c_r[k][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QB; k++) dv_vld[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < QB; k++) dv_vld[k] <= c_vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QB; k++) begin
        dv_d[k]    <= c_d[k];
        dv_h[k]    <= c_h[k];
        dv_zero[k] <= c_zero[k];
        dv_br[k]   <= c_br[k];
        for (int l = 0; l < 3; l++) begin
          dv_r[k][l]   <= r_nx[k][l];
          dv_q[k][l]   <= q_nx[k][l];
          dv_neg[k][l] <= c_neg[k][l];
          dv_ovf[k][l] <= c_ovf[k][l];
        end
      end
    end
  end

  // Sign, saturation and placement of the components by branch.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (dv_zero[QB-1]) begin
        f_t[l] = '0;
      end else if (dv_neg[QB-1][l]) begin
        if (dv_ovf[QB-1][l] || dv_q[QB-1][l] > SMIN) f_t[l] = SMIN;
        else                                       f_t[l] = W'(-dv_q[QB-1][l]);
      end else begin
        if (dv_ovf[QB-1][l] || dv_q[QB-1][l] > SMAX) f_t[l] = SMAX;
        else                                       f_t[l] = dv_q[QB-1][l];
      end
    end
    case (dv_br[QB-1])
      rmq_pkg::BR_TRACE: begin
        f_x = f_t[0]; f_y = f_t[1]; f_z = f_t[2]; f_w = dv_h[QB-1];
      end
      rmq_pkg::BR_X: begin
        f_x = dv_h[QB-1]; f_y = f_t[0]; f_z = f_t[1]; f_w = f_t[2];
      end
      rmq_pkg::BR_Y: begin
        f_y = dv_h[QB-1]; f_z = f_t[0]; f_x = f_t[1]; f_w = f_t[2];
      end
      default: begin
        f_z = dv_h[QB-1]; f_x = f_t[0]; f_y = f_t[1]; f_w = f_t[2];
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= dv_vld[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_x  <= f_x;
      o_y  <= f_y;
      o_z  <= f_z;
      o_w  <= f_w;
      o_br <= dv_br[QB-1];
    end
  end

  assign quat.valid        = o_vld;
  assign quat.quat_x       = o_x;
  assign quat.quat_y       = o_y;
  assign quat.quat_z       = o_z;
  assign quat.quat_w       = o_w;
  assign quat.branch_taken = o_br;

endmodule

`default_nettype wire

### hw/rtl/rmq_checker.sv
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks of the rotation matrix to quaternion block, bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rotation_matrix_to_quaternion_assert.svh"

module rmq_checker #(
  parameter int W = 16
) (
  input wire                 clk,
  input wire                 rst,
  input wire                 in_ready,
  input wire                 out_valid,
  input wire                 out_ready,
  input wire signed [W-1:0]  quat_x,
  input wire signed [W-1:0]  quat_w,
  input wire [1:0]           branch_taken
);

  // Reset empties the output.
  `RMQ_ASSERT_RST(a_rst_empty, rst |=> !out_valid, "output valid right after reset")

  // An empty output register never holds off the input.
  `RMQ_ASSERT(a_empty_ready, !out_valid |-> in_ready, "input stalled while output empty")

  // A stalled output beat keeps its payload.
  `RMQ_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(quat_x) && $stable(quat_w), "stalled beat changed")

  // The scalar part is a half root on the positive trace branch.
  `RMQ_ASSERT(a_w_pos, out_valid && branch_taken == rmq_pkg::BR_TRACE |-> !quat_w[W-1], "negative w on trace branch")

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(
  .W (WORD_BITS)
) u_rmq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (mat.ready),
  .out_valid    (quat.valid),
  .out_ready    (quat.ready),
  .quat_x       (quat.quat_x),
  .quat_w       (quat.quat_w),
  .branch_taken (quat.branch_taken)
);

`default_nettype wire

### tb/sv/rotation_matrix_to_quaternion_tb.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// Drives matrix beats into the quaternion converter, predicts each quaternion
// in fixed point, and compares every output beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module rotation_matrix_to_quaternion_tb;

  localparam int WB = 16;
  localparam int FB = 14;
  localparam int LATENCY = 40;
  localparam longint ONE = 64'sd1 << FB;
  localparam longint SMAX = (64'sd1 << (WB - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [WB-1:0] x, y, z, w;
    rmq_pkg::branch_t br;
  } quat_t;

  typedef logic signed [WB-1:0] mat_t [3][3];

  logic clk = 1'b0;
  logic rst = 1'b1;

  rmq_mat_if  #(.W(WB)) mat ();
  rmq_quat_if #(.W(WB)) quat ();

  rotation_matrix_to_quaternion #(.WORD_BITS(WB), .FRAC_BITS(FB)) DUT (
    .clk(clk), .rst(rst), .mat(mat.sink), .quat(quat.source)
  );

  quat_t expected_quats[$];
  int mismatches = 0;
  int cycles = 0;
  bit sink_hold = 1'b0;
  bit quiet = 1'b0;
  int idle_pct = 10;

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog on total cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Integer square root of a * 2^FB, one bit per step.
  function automatic longint isqrt_scaled(longint a);
    longint v, r, b;
    v = a << FB;
    r = 0;
    b = 64'sd1 << 60;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - r - b;
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint sat(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  // d * 2^FB / 2s, magnitude rounded half away from zero.
  function automatic longint div_term(longint d, longint s);
    longint mag, q;
    if (s == 0) return 0;
    mag = (d < 0) ? -d : d;
    q = ((mag << FB) + s) / (s << 1);
    return sat((d < 0) ? -q : q);
  endfunction

  function automatic quat_t predict_quat(mat_t m);
    longint e [3][3];
    longint q [4];
    longint tr, a, s;
    int i, j, k;
    quat_t res;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        e[r][c] = longint'(m[r][c]);
    tr = e[0][0] + e[1][1] + e[2][2];
    if (tr > 0) begin
      s = isqrt_scaled(tr + ONE);
      q[3] = sat((s + 1) >> 1);
      q[0] = div_term(e[1][2] - e[2][1], s);
      q[1] = div_term(e[2][0] - e[0][2], s);
      q[2] = div_term(e[0][1] - e[1][0], s);
      res.br = rmq_pkg::BR_TRACE;
    end else begin
      i = 0;
      if (e[1][1] > e[0][0]) i = 1;
      if (e[2][2] > e[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      a = e[i][i] - (e[j][j] + e[k][k]) + ONE;
      if (a < 0) a = 0;
      s = isqrt_scaled(a);
      q[i] = sat((s + 1) >> 1);
      q[j] = div_term(e[i][j] + e[j][i], s);
      q[k] = div_term(e[i][k] + e[k][i], s);
      q[3] = div_term(e[j][k] - e[k][j], s);
      res.br = (i == 0) ? rmq_pkg::BR_X : (i == 1) ? rmq_pkg::BR_Y : rmq_pkg::BR_Z;
    end
    res.x = q[0][WB-1:0];
    res.y = q[1][WB-1:0];
    res.z = q[2][WB-1:0];
    res.w = q[3][WB-1:0];
    return res;
  endfunction

  // Send one matrix beat, with a random gap in front of it. Valid stays up
  // after the beat so that the next one can follow directly; the gap loop and
  // wait_drained drop it.
  task automatic send_matrix(mat_t m);
    while (!quiet && $urandom_range(99) < idle_pct) begin
      mat.valid <= 1'b0;
      @(negedge clk);
    end
    mat.valid <= 1'b1;
    mat.m_r0c0 <= m[0][0]; mat.m_r0c1 <= m[0][1]; mat.m_r0c2 <= m[0][2];
    mat.m_r1c0 <= m[1][0]; mat.m_r1c1 <= m[1][1]; mat.m_r1c2 <= m[1][2];
    mat.m_r2c0 <= m[2][0]; mat.m_r2c1 <= m[2][1]; mat.m_r2c2 <= m[2][2];
    do @(posedge clk); while (!mat.ready);
    expected_quats.push_back(predict_quat(m));
    @(negedge clk);
  endtask

  function automatic mat_t rand_matrix();
    mat_t m;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        m[r][c] = 16'($urandom);
    return m;
  endfunction

  // A matrix near a rotation: small noise on a signed permutation-like pattern.
  function automatic mat_t near_rotation();
    mat_t m;
    int p;
    p = $urandom_range(5);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        m[r][c] = $signed(16'($urandom_range(12000))) - 16'sd6000;
    for (int r = 0; r < 3; r++)
      m[r][(r + p) % 3] = $urandom_range(1) ? 16'(14000 + $urandom_range(2384))
                                           : 16'(-14000 - $urandom_range(2384));
    return m;
  endfunction

  function automatic mat_t diag_matrix(int a, int b, int c);
    mat_t m;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        m[r][k] = '0;
    m[0][0] = 16'(a); m[1][1] = 16'(b); m[2][2] = 16'(c);
    m[0][1] = 16'sd100; m[1][0] = -16'sd300; m[1][2] = 16'sd2000; m[2][1] = 16'sd50;
    m[0][2] = -16'sd700; m[2][0] = 16'sd900;
    return m;
  endfunction

  // Output side: random stall, long hold when asked, and in-order compare.
  always @(negedge clk) begin
    if (rst) quat.ready <= 1'b0;
    else quat.ready <= !sink_hold && (quiet || $urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    quat_t e;
    if (!rst && quat.valid && quat.ready) begin
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected quaternion beat");
      end else begin
        e = expected_quats.pop_front();
        if (quat.quat_x !== e.x || quat.quat_y !== e.y || quat.quat_z !== e.z ||
            quat.quat_w !== e.w || quat.branch_taken !== e.br) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp x=%0d y=%0d z=%0d w=%0d br=%0d got %0d %0d %0d %0d %0d",
                     e.x, e.y, e.z, e.w, e.br, quat.quat_x, quat.quat_y,
                     quat.quat_z, quat.quat_w, quat.branch_taken);
        end
      end
    end
  end

  // Stop offering beats and wait for every expected result.
  task automatic wait_drained();
    mat.valid <= 1'b0;
    while (expected_quats.size() != 0) @(negedge clk);
  endtask

  // Field extremes, every branch, ties, zero trace.
  task automatic test_directed();
    mat_t m;
    send_matrix(diag_matrix(16384, 16384, 16384));
    send_matrix(diag_matrix(16384, -16384, -16384));
    send_matrix(diag_matrix(-16384, 16384, -16384));
    send_matrix(diag_matrix(-16384, -16384, 16384));
    send_matrix(diag_matrix(0, 0, 0));
    send_matrix(diag_matrix(100, -50, -50));
    send_matrix(diag_matrix(-100, -100, -100));
    send_matrix(diag_matrix(-200, 100, 100));
    send_matrix(diag_matrix(-32768, -32768, -32768));
    send_matrix(diag_matrix(32767, 32767, 32767));
    send_matrix(diag_matrix(-32768, 32767, 32767));
    send_matrix(diag_matrix(-1, 0, 0));
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        m[r][c] = -16'sd32768;
    send_matrix(m);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        m[r][c] = 16'sd32767;
    send_matrix(m);
    m[0][0] = -16'sd16384; m[1][1] = -16'sd16384; m[2][2] = 16'sd1;
    send_matrix(m);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        m[r][c] = (r == c) ? -16'sd32768 : 16'sd32767;
    send_matrix(m);
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering beats.
  task automatic test_backpressure();
    fork
      begin
        sink_hold = 1'b1;
        repeat (300) @(negedge clk);
        sink_hold = 1'b0;
      end
      for (int n = 0; n < 80; n++) send_matrix(near_rotation());
    join
    wait_drained();
  endtask

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      quiet = (n >= 200 && n < 320);
      if ($urandom_range(99) < 75) send_matrix(near_rotation());
      else send_matrix(rand_matrix());
    end
    quiet = 1'b0;
  endtask

  initial begin
    mat.valid = 1'b0;
    mat.m_r0c0 = '0; mat.m_r0c1 = '0; mat.m_r0c2 = '0;
    mat.m_r1c0 = '0; mat.m_r1c1 = '0; mat.m_r1c2 = '0;
    mat.m_r2c0 = '0; mat.m_r2c1 = '0; mat.m_r2c2 = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_backpressure();
    test_random(650);
    wait_drained();
    repeat (LATENCY) @(negedge clk);
    if (mismatches == 0 && expected_quats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
